>>> src/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg
// Shared widths, codes and helpers for the slab class allocator.
// ----------------------------------------------------------------------------
package sca_pkg;

  localparam int NUM_CLASSES = 16;
  localparam int MAX_SLABS   = 4096;
  localparam int FREE_DEPTH  = 1024;

  localparam int MODE_W     = 2;
  localparam int CLS_W      = 4;
  localparam int BYTES_W    = 27;
  localparam int ADDR_W     = 38;
  localparam int STAT_W     = 2;
  localparam int MB_W       = 7;
  localparam int CNT_W      = 13;
  localparam int GROWTH_W   = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;

  localparam int MIB_SHIFT = 20;
  localparam int MB_MAX    = 64;
  localparam int Q_SHIFT   = 8;

  localparam int PTR_W    = $clog2(FREE_DEPTH);
  localparam int USED_W   = $clog2(FREE_DEPTH + 1);
  localparam int MEM_D    = NUM_CLASSES * FREE_DEPTH;
  localparam int MEM_AW   = $clog2(MEM_D);
  localparam int BUILD_W  = BYTES_W + GROWTH_W - Q_SHIFT;
  localparam int DIVC_W   = $clog2(BYTES_W);

  localparam logic [MB_W-1:0]     SLAB_MB_RST   = 7'd2;
  localparam logic [CNT_W-1:0]    SLAB_CNT_RST  = 13'd1024;
  localparam logic [BYTES_W-1:0]  BASE_RST      = 27'd1200;
  localparam logic [GROWTH_W-1:0] GROWTH_RST    = 11'd512;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_LOOKUP = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SLAB  = 2'd1,
    STAT_BAD      = 2'd2,
    STAT_FREE_FUL = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAB_MB  = 2'd0,
    CFG_SLAB_CNT = 2'd1,
    CFG_BASE     = 2'd2,
    CFG_GROWTH   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_BUILD,
    ST_IDLE,
    ST_DISP,
    ST_LOOK,
    ST_POP,
    ST_DIV,
    ST_CARVE,
    ST_DONE
  } state_t;

  // effective slab size in MiB: MiB count clamped to 1..64
  function automatic logic [MB_W-1:0] mb_eff(input logic [MB_W-1:0] mb);
    logic [MB_W-1:0] m;
    m = mb;
    if (m == '0) m = MB_W'(1);
    if (int'(m) > MB_MAX) m = MB_W'(MB_MAX);
    return m;
  endfunction

  function automatic logic [BYTES_W-1:0] slab_bytes(input logic [MB_W-1:0] mb);
    return BYTES_W'({mb_eff(mb), {MIB_SHIFT{1'b0}}});
  endfunction

endpackage

>>> src/sca_if.sv
// ----------------------------------------------------------------------------
// sca_if
// Valid/ready channels of the slab class allocator: request, response, config.
// ----------------------------------------------------------------------------
interface sca_req_if;
  logic                            valid;
  logic                            ready;
  logic [sca_pkg::MODE_W-1:0]      mode;
  logic [sca_pkg::CLS_W-1:0]       class_sel;
  logic [sca_pkg::BYTES_W-1:0]     request_bytes;
  logic [sca_pkg::ADDR_W-1:0]      release_addr;
  modport source (output valid, mode, class_sel, request_bytes, release_addr, input ready);
  modport sink   (input valid, mode, class_sel, request_bytes, release_addr, output ready);
endinterface

interface sca_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [sca_pkg::ADDR_W-1:0]  item_addr;
  logic [sca_pkg::CLS_W-1:0]   class_out;
  logic [sca_pkg::STAT_W-1:0]  status;
  modport source (output valid, item_addr, class_out, status, input ready);
  modport sink   (input valid, item_addr, class_out, status, output ready);
endinterface

interface sca_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sca_pkg::CFG_IDX_W-1:0]   index;
  logic [sca_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/slab_class_allocator_top.sv
// ----------------------------------------------------------------------------
// slab_class_allocator_top
// Slab allocator for one partition: class lookup, alloc and free per word.
// ----------------------------------------------------------------------------
// Path from accept to response: free, bad request or carve from the current
//   slab DISP, DONE; alloc from free list DISP, POP, DONE; alloc opening a
//   new slab DISP, DIV (27-step remainder), CARVE, DONE; lookup DISP, LOOK
//   (one class a cycle), DONE. Flow: one request word at a time; ready drops
//   from accept until the result word appears.
// Reset (synchronous): registers take their defaults, all class state clears,
//   then the table build walks every class with req.ready low. Any config
//   write reruns that build. The free list store is not cleared.
module slab_class_allocator_top (
  input  logic        clk,
  input  logic        rst,
  sca_req_if.sink     req,
  sca_rsp_if.source   rsp,
  sca_cfg_if.sink     cfg
);

  // configuration registers
  logic [sca_pkg::MB_W-1:0]     slab_mb;
  logic [sca_pkg::CNT_W-1:0]    slab_count;
  logic [sca_pkg::BYTES_W-1:0]  base_item_bytes;
  logic [sca_pkg::GROWTH_W-1:0] growth_q8;

  // per-class state, all read through one shared index (sel)
  logic [sca_pkg::BYTES_W-1:0] class_bytes  [sca_pkg::NUM_CLASSES];
  logic [sca_pkg::ADDR_W-1:0]  carve_offset [sca_pkg::NUM_CLASSES];
  logic [sca_pkg::BYTES_W-1:0] bytes_left   [sca_pkg::NUM_CLASSES];
  logic [sca_pkg::PTR_W-1:0]   free_head    [sca_pkg::NUM_CLASSES];
  logic [sca_pkg::PTR_W-1:0]   free_tail    [sca_pkg::NUM_CLASSES];
  logic [sca_pkg::USED_W-1:0]  free_used    [sca_pkg::NUM_CLASSES];
  logic [sca_pkg::CNT_W-1:0]   slabs_taken;

  // free list store, no reset
  logic [sca_pkg::ADDR_W-1:0]  free_store [sca_pkg::MEM_D];
  logic [sca_pkg::ADDR_W-1:0]  mem_rdata;
  logic [sca_pkg::MEM_AW-1:0]  mem_waddr, mem_raddr;
  logic                        mem_we;

  sca_pkg::state_t state, state_next;
  logic [sca_pkg::CLS_W-1:0]   sel;
  logic [sca_pkg::BUILD_W-1:0] build_s;
  logic [sca_pkg::DIVC_W-1:0]  div_bit;
  logic [sca_pkg::BYTES_W-1:0] div_rem;

  // latched request word
  sca_pkg::mode_t              r_mode;
  logic [sca_pkg::CLS_W-1:0]   r_cls;
  logic [sca_pkg::BYTES_W-1:0] r_req;
  logic [sca_pkg::ADDR_W-1:0]  r_addr;

  // pending result
  logic [sca_pkg::ADDR_W-1:0]  res_addr;
  logic [sca_pkg::CLS_W-1:0]   res_cls;
  sca_pkg::status_t            res_stat;
  sca_pkg::status_t            disp_stat;

  logic [sca_pkg::ADDR_W-1:0]  out_addr;
  logic [sca_pkg::CLS_W-1:0]   out_cls;
  logic [sca_pkg::STAT_W-1:0]  out_stat;
  logic                        out_valid;

  logic cfg_acc, req_acc, out_load;

  // shared derived values
  logic [sca_pkg::BYTES_W-1:0]     sb;
  logic [sca_pkg::CNT_W-1:0]       total;
  logic [sca_pkg::BYTES_W-1:0]     sz;
  logic [sca_pkg::BUILD_W-1:0]     b_src, b_cap;
  logic [sca_pkg::BYTES_W-1:0]     b_val;
  logic [sca_pkg::BYTES_W+sca_pkg::GROWTH_W-1:0] b_prod;
  logic [sca_pkg::BYTES_W:0]       div_sh;
  logic [sca_pkg::CNT_W-1:0]       new_idx;
  logic [sca_pkg::CNT_W+sca_pkg::MB_W-1:0] idx_mb;
  logic [sca_pkg::BYTES_W-1:0]     full_left;
  logic bad_cls, look_bad, look_hit, last_cls, fifo_full, fifo_some, have_room, slab_avail;

  assign cfg_acc  = cfg.valid && cfg.ready;
  assign req_acc  = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign sb    = sca_pkg::slab_bytes(slab_mb);
  assign total = (int'(slab_count) > sca_pkg::MAX_SLABS) ?
                 sca_pkg::CNT_W'(sca_pkg::MAX_SLABS) : slab_count;
  assign sz    = class_bytes[sel];

  // table build: one class a cycle through the shared multiplier
  assign b_src  = (sel == '0) ? sca_pkg::BUILD_W'(base_item_bytes) : build_s;
  assign b_cap  = (b_src > sca_pkg::BUILD_W'(sb)) ? sca_pkg::BUILD_W'(sb) : b_src;
  assign b_val  = (b_cap == '0) ? sca_pkg::BYTES_W'(1) : b_cap[sca_pkg::BYTES_W-1:0];
  assign b_prod = b_val * growth_q8;

  // restoring division, remainder only: slab rounded down to whole items
  assign div_sh    = {div_rem, sb[div_bit]};
  assign full_left = sb - div_rem;

  assign new_idx = total - sca_pkg::CNT_W'(1) - slabs_taken;
  assign idx_mb  = {sca_pkg::MB_W'(0), new_idx} *
                   {sca_pkg::CNT_W'(0), sca_pkg::mb_eff(slab_mb)};

  assign bad_cls    = int'(r_cls) >= sca_pkg::NUM_CLASSES;
  assign look_bad   = (r_req == '0) || (r_req > sb);
  assign look_hit   = r_req <= sz;
  assign last_cls   = sel == sca_pkg::CLS_W'(sca_pkg::NUM_CLASSES - 1);
  assign fifo_full  = int'(free_used[sel]) >= sca_pkg::FREE_DEPTH;
  assign fifo_some  = free_used[sel] != '0;
  assign have_room  = bytes_left[sel] >= sz;
  assign slab_avail = slabs_taken < total;

  assign mem_waddr = sca_pkg::MEM_AW'(int'(sel) * sca_pkg::FREE_DEPTH + int'(free_tail[sel]));
  assign mem_raddr = sca_pkg::MEM_AW'(int'(sel) * sca_pkg::FREE_DEPTH + int'(free_head[sel]));

  // status settled at dispatch; lookup misses are added while scanning
  always_comb begin
    disp_stat = sca_pkg::STAT_OK;
    case (r_mode)
      sca_pkg::MODE_LOOKUP: if (look_bad) disp_stat = sca_pkg::STAT_BAD;
      sca_pkg::MODE_FREE: begin
        if (bad_cls) disp_stat = sca_pkg::STAT_BAD;
        else if (fifo_full) disp_stat = sca_pkg::STAT_FREE_FUL;
      end
      sca_pkg::MODE_ALLOC: begin
        if (bad_cls) disp_stat = sca_pkg::STAT_BAD;
        else if (!fifo_some && !have_room && !slab_avail) disp_stat = sca_pkg::STAT_NO_SLAB;
      end
      default: disp_stat = sca_pkg::STAT_BAD;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sca_pkg::ST_BUILD: if (last_cls) state_next = sca_pkg::ST_IDLE;
      sca_pkg::ST_IDLE:  if (req_acc) state_next = sca_pkg::ST_DISP;
      sca_pkg::ST_DISP: begin
        case (r_mode)
          sca_pkg::MODE_LOOKUP: state_next = look_bad ? sca_pkg::ST_DONE : sca_pkg::ST_LOOK;
          sca_pkg::MODE_ALLOC: begin
            if (bad_cls) state_next = sca_pkg::ST_DONE;
            else if (fifo_some) state_next = sca_pkg::ST_POP;
            else if (!have_room && slab_avail) state_next = sca_pkg::ST_DIV;
            else state_next = sca_pkg::ST_DONE;
          end
          default: state_next = sca_pkg::ST_DONE;
        endcase
      end
      sca_pkg::ST_LOOK:  if (look_hit || last_cls) state_next = sca_pkg::ST_DONE;
      sca_pkg::ST_POP:   state_next = sca_pkg::ST_DONE;
      sca_pkg::ST_DIV:   if (div_bit == '0) state_next = sca_pkg::ST_CARVE;
      sca_pkg::ST_CARVE: state_next = sca_pkg::ST_DONE;
      sca_pkg::ST_DONE:  if (!out_valid || rsp.ready) state_next = sca_pkg::ST_IDLE;
      default:           state_next = sca_pkg::ST_IDLE;
    endcase
    if (cfg_acc) state_next = sca_pkg::ST_BUILD;
  end

  // handshake outputs
  always_comb begin
    req.ready = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    case (state)
      sca_pkg::ST_IDLE: req.ready = 1'b1;
      sca_pkg::ST_DONE: out_load  = !out_valid || rsp.ready;
      sca_pkg::ST_DISP: mem_we    = (r_mode == sca_pkg::MODE_FREE) && !bad_cls && !fifo_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sca_pkg::ST_BUILD;
    end else begin
      state <= state_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      slab_mb         <= sca_pkg::SLAB_MB_RST;
      slab_count      <= sca_pkg::SLAB_CNT_RST;
      base_item_bytes <= sca_pkg::BASE_RST;
      growth_q8       <= sca_pkg::GROWTH_RST;
    end else if (cfg_acc) begin
      case (sca_pkg::cfg_idx_t'(cfg.index))
        sca_pkg::CFG_SLAB_MB:  slab_mb         <= cfg.data[sca_pkg::MB_W-1:0];
        sca_pkg::CFG_SLAB_CNT: slab_count      <= cfg.data[sca_pkg::CNT_W-1:0];
        sca_pkg::CFG_BASE:     base_item_bytes <= cfg.data[sca_pkg::BYTES_W-1:0];
        sca_pkg::CFG_GROWTH:   growth_q8       <= cfg.data[sca_pkg::GROWTH_W-1:0];
        default: ;
      endcase
    end
  end

  // free list store
  always_ff @(posedge clk) begin
    if (mem_we) free_store[mem_waddr] <= r_addr;
    mem_rdata <= free_store[mem_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_acc) begin
      r_mode <= sca_pkg::mode_t'(req.mode);
      r_cls  <= req.class_sel;
      r_req  <= req.request_bytes;
      r_addr <= req.release_addr;
    end
    case (state)
      sca_pkg::ST_BUILD: build_s <= b_prod[sca_pkg::BYTES_W+sca_pkg::GROWTH_W-1:sca_pkg::Q_SHIFT];
      sca_pkg::ST_DISP: begin
        res_addr <= (r_mode == sca_pkg::MODE_ALLOC && !bad_cls && !fifo_some && have_room) ?
                    carve_offset[sel] : '0;
        res_cls  <= (r_mode == sca_pkg::MODE_LOOKUP) ? '0 : r_cls;
        res_stat <= disp_stat;
        div_bit  <= sca_pkg::DIVC_W'(sca_pkg::BYTES_W - 1);
        div_rem  <= '0;
      end
      sca_pkg::ST_LOOK: begin
        if (look_hit) res_cls <= sel;
        else if (last_cls) res_stat <= sca_pkg::STAT_BAD;
      end
      sca_pkg::ST_POP:   res_addr <= mem_rdata;
      sca_pkg::ST_DIV: begin
        div_rem <= (div_sh >= {1'b0, sz}) ? sca_pkg::BYTES_W'(div_sh - {1'b0, sz}) :
                                            div_sh[sca_pkg::BYTES_W-1:0];
        div_bit <= div_bit - sca_pkg::DIVC_W'(1);
      end
      sca_pkg::ST_CARVE: res_addr <= carve_offset[sel];
      default: ;
    endcase
    if (out_load) begin
      out_addr <= res_addr;
      out_cls  <= res_cls;
      out_stat <= res_stat;
    end
  end

  // shared class index: build walk, request class, lookup scan
  always_ff @(posedge clk) begin
    if (rst || cfg_acc) begin
      sel <= '0;
    end else begin
      case (state)
        sca_pkg::ST_BUILD: sel <= sel + sca_pkg::CLS_W'(1);
        sca_pkg::ST_IDLE:  if (req_acc) sel <= req.class_sel;
        sca_pkg::ST_DISP:  if (r_mode == sca_pkg::MODE_LOOKUP) sel <= '0;
        sca_pkg::ST_LOOK:  if (!look_hit && !last_cls) sel <= sel + sca_pkg::CLS_W'(1);
        default: ;
      endcase
    end
  end

  // control and class state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      slabs_taken <= '0;
      for (int i = 0; i < sca_pkg::NUM_CLASSES; i++) begin
        carve_offset[i] <= '0;
        bytes_left[i]   <= '0;
        free_head[i]    <= '0;
        free_tail[i]    <= '0;
        free_used[i]    <= '0;
      end
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
      case (state)
        sca_pkg::ST_BUILD: class_bytes[sel] <= b_val;
        sca_pkg::ST_DISP: begin
          case (r_mode)
            sca_pkg::MODE_FREE: begin
              if (!bad_cls && !fifo_full) begin
                free_tail[sel] <= (int'(free_tail[sel]) == sca_pkg::FREE_DEPTH - 1) ?
                                  '0 : free_tail[sel] + sca_pkg::PTR_W'(1);
                free_used[sel] <= free_used[sel] + sca_pkg::USED_W'(1);
              end
            end
            sca_pkg::MODE_ALLOC: begin
              if (!bad_cls) begin
                if (fifo_some) begin
                  free_head[sel] <= (int'(free_head[sel]) == sca_pkg::FREE_DEPTH - 1) ?
                                    '0 : free_head[sel] + sca_pkg::PTR_W'(1);
                  free_used[sel] <= free_used[sel] - sca_pkg::USED_W'(1);
                end else if (have_room) begin
                  carve_offset[sel] <= carve_offset[sel] + sca_pkg::ADDR_W'(sz);
                  bytes_left[sel]   <= bytes_left[sel] - sz;
                end else if (slab_avail) begin
                  slabs_taken       <= slabs_taken + sca_pkg::CNT_W'(1);
                  carve_offset[sel] <= sca_pkg::ADDR_W'({idx_mb, {sca_pkg::MIB_SHIFT{1'b0}}});
                end
              end
            end
            default: ;
          endcase
        end
        sca_pkg::ST_CARVE: begin
          carve_offset[sel] <= carve_offset[sel] + sca_pkg::ADDR_W'(sz);
          bytes_left[sel]   <= full_left - sz;
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.item_addr = out_addr;
  assign rsp.class_out = out_cls;
  assign rsp.status    = out_stat;

endmodule

>>> src/sca_checker.sv
// ----------------------------------------------------------------------------
// sca_checker
// Port-level checks on the slab class allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sca_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [sca_pkg::ADDR_W-1:0]    item_addr,
  input logic [sca_pkg::STAT_W-1:0]    status
);

  // no response straight out of reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // busy once a word is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready high right after accept");

  // failures never hand out an address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != sca_pkg::STAT_OK |-> item_addr == '0)
    else $error("address on failed request");

  // stalled response holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(item_addr) && $stable(status))
    else $error("stalled response changed");

endmodule

bind slab_class_allocator_top sca_checker u_sca_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .item_addr (rsp.item_addr),
  .status    (rsp.status)
);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the slab class allocator word by word against a predictor of its own:
// directed lookups, allocs and frees, free list order, exhausted slabs,
// register extremes, back-pressure and random traffic.
// ----------------------------------------------------------------------------
module testbench;

  localparam int     LIMIT    = 2000000;
  localparam int     SETTLE   = 40;
  localparam longint ADDR_MSK = 64'h3F_FFFF_FFFF;

  logic clk;
  logic rst;

  sca_req_if req ();
  sca_rsp_if rsp ();
  sca_cfg_if cfg ();

  slab_class_allocator_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // one expected response word
  typedef struct {
    logic [sca_pkg::ADDR_W-1:0] addr;
    logic [sca_pkg::CLS_W-1:0]  cls;
    sca_pkg::status_t           stat;
  } reply_t;

  reply_t                     replies_due[$];
  logic [sca_pkg::ADDR_W-1:0] handed_out[$];   // addresses given out, reused for frees
  int                         errors;
  int                         cycles = 0;
  int                         words_sent;
  int                         replies_seen;

  // allocator state as the predictor sees it
  longint unsigned   reg_mb, reg_cnt, reg_base, reg_growth;
  longint unsigned   cls_size   [sca_pkg::NUM_CLASSES];
  longint unsigned   carve_ptr  [sca_pkg::NUM_CLASSES];
  longint unsigned   slab_room  [sca_pkg::NUM_CLASSES];
  int unsigned       fifo_rd    [sca_pkg::NUM_CLASSES];
  int unsigned       fifo_wr    [sca_pkg::NUM_CLASSES];
  int unsigned       fifo_cnt   [sca_pkg::NUM_CLASSES];
  longint unsigned   fifo_mem   [sca_pkg::NUM_CLASSES*sca_pkg::FREE_DEPTH];
  longint unsigned   slabs_used;

  // stimulus shaping
  bit gaps_on;
  int burst_left;
  int stall_pct;
  bit hold_start;

  function automatic longint unsigned slab_span();
    longint unsigned m;
    m = reg_mb;
    if (m == 0) m = 1;
    if (m > sca_pkg::MB_MAX) m = sca_pkg::MB_MAX;
    return m << sca_pkg::MIB_SHIFT;
  endfunction

  function automatic longint unsigned slab_total();
    return (reg_cnt > sca_pkg::MAX_SLABS) ? sca_pkg::MAX_SLABS : reg_cnt;
  endfunction

  function automatic void rebuild_sizes();
    longint unsigned cap, s;
    cap = slab_span();
    s   = reg_base;
    for (int i = 0; i < sca_pkg::NUM_CLASSES; i++) begin
      if (s > cap) s = cap;
      if (s == 0) s = 1;
      cls_size[i] = s;
      s = (s * reg_growth) >> sca_pkg::Q_SHIFT;
    end
  endfunction

  function automatic void clear_state();
    reg_mb     = sca_pkg::SLAB_MB_RST;
    reg_cnt    = sca_pkg::SLAB_CNT_RST;
    reg_base   = sca_pkg::BASE_RST;
    reg_growth = sca_pkg::GROWTH_RST;
    slabs_used = 0;
    for (int i = 0; i < sca_pkg::NUM_CLASSES; i++) begin
      carve_ptr[i] = 0; slab_room[i] = 0;
      fifo_rd[i] = 0; fifo_wr[i] = 0; fifo_cnt[i] = 0;
    end
    rebuild_sizes();
  endfunction

  function automatic void apply_reg(sca_pkg::cfg_idx_t idx, longint unsigned val);
    case (idx)
      sca_pkg::CFG_SLAB_MB:  reg_mb     = val & 64'h7F;
      sca_pkg::CFG_SLAB_CNT: reg_cnt    = val & 64'h1FFF;
      sca_pkg::CFG_BASE:     reg_base   = val & 64'h7FF_FFFF;
      sca_pkg::CFG_GROWTH:   reg_growth = val & 64'h7FF;
      default: ;
    endcase
    rebuild_sizes();
  endfunction

  // works out the reply to one accepted word and updates the allocator state
  function automatic reply_t serve_word(sca_pkg::mode_t m, int unsigned c,
                                        longint unsigned nbytes, longint unsigned raddr);
    reply_t          r;
    longint unsigned sz, sb, idx;
    int unsigned     k;
    bit              have;
    nbytes = nbytes & 64'h7FF_FFFF;
    r.addr = '0;
    r.cls  = c[sca_pkg::CLS_W-1:0];
    r.stat = sca_pkg::STAT_OK;
    if (m == sca_pkg::MODE_LOOKUP) begin
      r.cls = '0;
      if (nbytes == 0 || nbytes > slab_span()) begin
        r.stat = sca_pkg::STAT_BAD;
      end else begin
        k = 0;
        while (k < sca_pkg::NUM_CLASSES && nbytes > cls_size[k]) k++;
        if (k >= sca_pkg::NUM_CLASSES) r.stat = sca_pkg::STAT_BAD;
        else r.cls = k[sca_pkg::CLS_W-1:0];
      end
    end else if (m == sca_pkg::MODE_NONE) begin
      r.stat = sca_pkg::STAT_BAD;
    end else if (m == sca_pkg::MODE_FREE) begin
      if (fifo_cnt[c] >= sca_pkg::FREE_DEPTH) begin
        r.stat = sca_pkg::STAT_FREE_FUL;
      end else begin
        fifo_mem[c*sca_pkg::FREE_DEPTH + fifo_wr[c]] = raddr & ADDR_MSK;
        fifo_wr[c] = (fifo_wr[c] + 1) % sca_pkg::FREE_DEPTH;
        fifo_cnt[c]++;
      end
    end else begin
      sz = cls_size[c];
      if (fifo_cnt[c] > 0) begin
        r.addr = fifo_mem[c*sca_pkg::FREE_DEPTH + fifo_rd[c]];
        fifo_rd[c] = (fifo_rd[c] + 1) % sca_pkg::FREE_DEPTH;
        fifo_cnt[c]--;
      end else begin
        have = slab_room[c] >= sz;
        if (!have && slabs_used < slab_total()) begin
          sb  = slab_span();
          idx = slab_total() - 1 - slabs_used;
          slabs_used++;
          carve_ptr[c] = (idx * sb) & ADDR_MSK;
          slab_room[c] = (sb / sz) * sz;
          have = 1;
        end
        if (have) begin
          r.addr       = carve_ptr[c];
          carve_ptr[c] = (carve_ptr[c] + sz) & ADDR_MSK;
          slab_room[c] -= sz;
        end else begin
          r.stat = sca_pkg::STAT_NO_SLAB;
        end
      end
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // clock, watchdog
  // -------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // response side: stall pattern plus an occasional long hold-off
  // -------------------------------------------------------------------------
  initial begin
    rsp.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        rsp.ready  = 1'b0;
        repeat (300) @(negedge clk);   // block fills and stalls its input
      end else begin
        rsp.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // compare every accepted response word with the oldest expectation
  always @(posedge clk) begin
    reply_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        $error("response word with nothing expected");
        errors++;
      end else begin
        e = replies_due.pop_front();
        if (rsp.item_addr !== e.addr) begin
          $error("item_addr: expected %h, got %h", e.addr, rsp.item_addr);
          errors++;
        end
        if (rsp.class_out !== e.cls) begin
          $error("class_out: expected %0d, got %0d", e.cls, rsp.class_out);
          errors++;
        end
        if (rsp.status !== e.stat) begin
          $error("status: expected %0d, got %0d", e.stat, rsp.status);
          errors++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // request side
  // -------------------------------------------------------------------------
  task automatic send_word(sca_pkg::mode_t m, int unsigned c, longint unsigned nbytes,
                           longint unsigned raddr);
    int     gap;
    reply_t r;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(8);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(20, 1);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    req.valid         = 1'b1;
    req.mode          = m;
    req.class_sel     = c[sca_pkg::CLS_W-1:0];
    req.request_bytes = nbytes[sca_pkg::BYTES_W-1:0];
    req.release_addr  = raddr[sca_pkg::ADDR_W-1:0];
    do @(posedge clk); while (!req.ready);
    r = serve_word(m, c, nbytes, raddr);
    replies_due.insert(replies_due.size(), r);
    if (m == sca_pkg::MODE_ALLOC && r.stat == sca_pkg::STAT_OK)
      handed_out.insert(handed_out.size(), r.addr);
    words_sent++;
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  task automatic drain();
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(sca_pkg::cfg_idx_t idx, longint unsigned val);
    drain();
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = val[sca_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg.ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  function automatic longint unsigned rand_addr();
    return {$urandom, $urandom} & ADDR_MSK;
  endfunction

  // one random word; frees mostly return earlier addresses
  task automatic random_word();
    int              pick;
    longint unsigned a, nb;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_word(sca_pkg::MODE_ALLOC, $urandom_range(15), $urandom & 27'h7FF_FFFF,
                rand_addr());
    end else if (pick < 75) begin
      if (handed_out.size() > 0 && $urandom_range(9) < 7)
        a = handed_out[$urandom_range(handed_out.size() - 1)];
      else
        a = rand_addr();
      send_word(sca_pkg::MODE_FREE, $urandom_range(15), $urandom & 27'h7FF_FFFF, a);
    end else if (pick < 95) begin
      if ($urandom_range(3) == 0) nb = $urandom & 27'h7FF_FFFF;
      else nb = $urandom_range(slab_span() + 2);
      send_word(sca_pkg::MODE_LOOKUP, $urandom_range(15), nb, rand_addr());
    end else begin
      send_word(sca_pkg::MODE_NONE, $urandom_range(15), $urandom & 27'h7FF_FFFF,
                rand_addr());
    end
  endtask

  // -------------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------------
  task automatic test_directed();
    gaps_on = 0; stall_pct = 0;
    send_word(sca_pkg::MODE_LOOKUP, 0, 0, 0);                       // zero size
    send_word(sca_pkg::MODE_LOOKUP, 0, 1, 0);
    send_word(sca_pkg::MODE_LOOKUP, 0, slab_span(), 0);             // top class
    send_word(sca_pkg::MODE_LOOKUP, 0, slab_span() + 1, 0);         // too large
    send_word(sca_pkg::MODE_LOOKUP, 15, 27'h7FF_FFFF, ADDR_MSK);
    send_word(sca_pkg::MODE_LOOKUP, 0, 1201, 0);
    send_word(sca_pkg::MODE_ALLOC, 0, 0, 0);                        // opens a slab
    send_word(sca_pkg::MODE_ALLOC, 0, 0, 0);                        // carves from it
    send_word(sca_pkg::MODE_ALLOC, 15, 27'h7FF_FFFF, ADDR_MSK);
    send_word(sca_pkg::MODE_FREE, 15, 0, ADDR_MSK);                 // all-ones address
    send_word(sca_pkg::MODE_FREE, 15, 0, 0);
    send_word(sca_pkg::MODE_ALLOC, 15, 0, 0);                       // pops it back
    send_word(sca_pkg::MODE_ALLOC, 15, 0, 0);
    send_word(sca_pkg::MODE_ALLOC, 15, 0, 0);                       // free list empty again
    send_word(sca_pkg::MODE_NONE, 7, 27'h7FF_FFFF, ADDR_MSK);       // unused mode
    send_word(sca_pkg::MODE_NONE, 0, 0, 0);
  endtask

  task automatic test_free_fifo();
    gaps_on = 0; stall_pct = 10;
    for (int i = 0; i < 30; i++)
      send_word(sca_pkg::MODE_FREE, 3, 0, rand_addr());
    for (int i = 0; i < 34; i++)
      send_word(sca_pkg::MODE_ALLOC, 3, 0, 0);                      // pops in order, then carves
  endtask

  task automatic test_out_of_slabs();
    gaps_on = 1; stall_pct = 20;
    write_reg(sca_pkg::CFG_SLAB_CNT, 2);
    write_reg(sca_pkg::CFG_SLAB_MB, 1);
    for (int c = 4; c < 10; c++) send_word(sca_pkg::MODE_ALLOC, c, 0, 0);
    write_reg(sca_pkg::CFG_SLAB_CNT, 0);
    for (int c = 10; c < 16; c++) send_word(sca_pkg::MODE_ALLOC, c, 0, 0);
  endtask

  task automatic test_reg_extremes();
    gaps_on = 1; stall_pct = 30;
    // every class equal to one byte: lookups above it find no class
    write_reg(sca_pkg::CFG_GROWTH, 256);
    write_reg(sca_pkg::CFG_BASE, 1);
    write_reg(sca_pkg::CFG_SLAB_MB, 0);
    send_word(sca_pkg::MODE_LOOKUP, 0, 2, 0);
    send_word(sca_pkg::MODE_LOOKUP, 0, 1, 0);
    write_reg(sca_pkg::CFG_SLAB_MB, 127);                           // acts as 64
    write_reg(sca_pkg::CFG_BASE, 27'h7FF_FFFF);
    write_reg(sca_pkg::CFG_GROWTH, 2047);
    write_reg(sca_pkg::CFG_SLAB_CNT, 8191);
    send_word(sca_pkg::MODE_LOOKUP, 0, 64 << sca_pkg::MIB_SHIFT, 0);
    send_word(sca_pkg::MODE_LOOKUP, 0, (64 << sca_pkg::MIB_SHIFT) + 1, 0);
    send_word(sca_pkg::MODE_ALLOC, 1, 0, 0);
    write_reg(sca_pkg::CFG_BASE, 0);
    write_reg(sca_pkg::CFG_GROWTH, 0);
    send_word(sca_pkg::MODE_LOOKUP, 0, 1, 0);
    send_word(sca_pkg::MODE_ALLOC, 2, 0, 0);
    write_reg(sca_pkg::CFG_GROWTH, 1024);
    write_reg(sca_pkg::CFG_BASE, 64 << sca_pkg::MIB_SHIFT);
    write_reg(sca_pkg::CFG_SLAB_MB, 64);
    write_reg(sca_pkg::CFG_SLAB_CNT, 4096);
    send_word(sca_pkg::MODE_LOOKUP, 0, 1, 0);
  endtask

  task automatic test_back_pressure();
    gaps_on = 0; stall_pct = 0;
    hold_start = 1'b1;
    for (int i = 0; i < 12; i++) random_word();
    drain();                                               // sender waits it out
    for (int i = 0; i < 12; i++) random_word();
  endtask

  task automatic test_random();
    // small slabs often, so slabs run out and get carved in many classes
    longint unsigned mbs[4]  = '{1, 2, 8, 64};
    longint unsigned cnts[4] = '{6, 1024, 40, 4096};
    longint unsigned bases[4] = '{48, 1200, 3000, 100000};
    longint unsigned grows[4] = '{300, 512, 1024, 333};
    for (int p = 0; p < 4; p++) begin
      write_reg(sca_pkg::CFG_SLAB_MB, mbs[p]);
      write_reg(sca_pkg::CFG_SLAB_CNT, cnts[p]);
      write_reg(sca_pkg::CFG_BASE, bases[p]);
      write_reg(sca_pkg::CFG_GROWTH, grows[p]);
      gaps_on   = (p != 1);
      stall_pct = (p == 2) ? 0 : 25;
      for (int i = 0; i < 70; i++) random_word();
    end
  endtask

  // -------------------------------------------------------------------------
  // sequence
  // -------------------------------------------------------------------------
  initial begin
    errors = 0; words_sent = 0; replies_seen = 0;
    gaps_on = 0; burst_left = 0; stall_pct = 0; hold_start = 1'b0;
    req.valid = 1'b0; req.mode = sca_pkg::MODE_ALLOC; req.class_sel = '0;
    req.request_bytes = '0; req.release_addr = '0;
    cfg.valid = 1'b0; cfg.index = sca_pkg::CFG_SLAB_MB; cfg.data = '0;
    clear_state();
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_free_fifo();
    test_out_of_slabs();
    test_reg_extremes();
    test_back_pressure();
    test_random();
    drain();

    $display("Covered %0d request words and %0d response words: lookups, allocs, frees,",
             words_sent, replies_seen);
    $display("free list order, exhausted slabs, register extremes and a long output stall.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/sca_pkg.sv
src/sca_if.sv
src/slab_class_allocator_top.sv
src/sca_checker.sv
bench/testbench.sv
